@@ hw/rtl/csm_pkg.sv @@
// Shared types, codes and constants of the charger status monitor.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package csm_pkg;

  localparam int unsigned IntervalW = 21;
  localparam int unsigned ResIntervalW = 22;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ShortW = 16;
  localparam int unsigned ErrCntW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [ErrCntW-1:0] ErrCap = 3'd5;
  localparam logic [16:0] ErrIntervalCap = 17'd120000;

  typedef enum logic [1:0] {
    MODE_SAMPLE   = 2'd0,
    MODE_EDGE     = 2'd1,
    MODE_ACTIVITY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_CHARGING = 2'd0,
    ST_FULL     = 2'd1,
    ST_ERROR    = 2'd2
  } charge_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHARGING_INTERVAL  = 3'd0,
    REG_FULL_INTERVAL      = 3'd1,
    REG_ERROR_INTERVAL     = 3'd2,
    REG_INTERRUPT_INTERVAL = 3'd3,
    REG_DEBOUNCE           = 3'd4,
    REG_IDLE_TIMEOUT       = 3'd5,
    REG_EDGE_HOLDOFF       = 3'd6,
    REG_INTERRUPTS_ON      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [IntervalW-1:0] charging_interval_ms;
    logic [IntervalW-1:0] full_interval_ms;
    logic [IntervalW-1:0] error_interval_ms;
    logic [IntervalW-1:0] interrupt_interval_ms;
    logic [ShortW-1:0]    debounce_ms;
    logic [TimeW-1:0]     idle_limit_ms;
    logic [ShortW-1:0]    edge_holdoff_ms;
    logic                 interrupts_on;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [TimeW-1:0] now_ms;
    logic             pin_level;
    logic             read_error;
  } item_t;

  typedef struct packed {
    logic [1:0]              charge_state;
    logic                    state_changed;
    logic [ResIntervalW-1:0] next_interval_ms;
    logic                    check_now;
    logic                    interrupt_mode;
    logic [TimeW-1:0]        edge_count;
    logic [ErrCntW-1:0]      error_count;
    logic                    idle;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/csm_if.sv @@
// Channel interfaces of the charger status monitor: event requests,
// result requests and configuration writes. Depend on csm_pkg.
`default_nettype none

interface csm_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [csm_pkg::TimeW-1:0]  now_ms;
  logic                       pin_level;
  logic                       read_error;

  modport source (output valid, mode, now_ms, pin_level, read_error, input ready);
  modport sink (input valid, mode, now_ms, pin_level, read_error, output ready);
endinterface

interface csm_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        charge_state;
  logic                              state_changed;
  logic [csm_pkg::ResIntervalW-1:0]  next_interval_ms;
  logic                              check_now;
  logic                              interrupt_mode;
  logic [csm_pkg::TimeW-1:0]         edge_count;
  logic [csm_pkg::ErrCntW-1:0]       error_count;
  logic                              idle;

  modport source (output valid, charge_state, state_changed, next_interval_ms, check_now,
                  interrupt_mode, edge_count, error_count, idle, input ready);
  modport sink (input valid, charge_state, state_changed, next_interval_ms, check_now,
                interrupt_mode, edge_count, error_count, idle, output ready);
endinterface

interface csm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [csm_pkg::CfgIdxW-1:0]   index;
  logic [csm_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/csm_cfg_regs.sv @@
// Configuration register file of the charger status monitor.
// Depends on csm_pkg and csm_cfg_if.
`default_nettype none

module csm_cfg_regs (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  csm_cfg_if.sink        cfg_i,
  output csm_pkg::cfg_t  cfg_o
);

  csm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (csm_pkg::cfg_reg_e'(cfg_i.index))
        csm_pkg::REG_CHARGING_INTERVAL:
          cfg_d.charging_interval_ms = cfg_i.data[csm_pkg::IntervalW-1:0];
        csm_pkg::REG_FULL_INTERVAL:
          cfg_d.full_interval_ms = cfg_i.data[csm_pkg::IntervalW-1:0];
        csm_pkg::REG_ERROR_INTERVAL:
          cfg_d.error_interval_ms = cfg_i.data[csm_pkg::IntervalW-1:0];
        csm_pkg::REG_INTERRUPT_INTERVAL:
          cfg_d.interrupt_interval_ms = cfg_i.data[csm_pkg::IntervalW-1:0];
        csm_pkg::REG_DEBOUNCE:
          cfg_d.debounce_ms = cfg_i.data[csm_pkg::ShortW-1:0];
        csm_pkg::REG_IDLE_TIMEOUT:
          cfg_d.idle_limit_ms = cfg_i.data[csm_pkg::TimeW-1:0];
        csm_pkg::REG_EDGE_HOLDOFF:
          cfg_d.edge_holdoff_ms = cfg_i.data[csm_pkg::ShortW-1:0];
        csm_pkg::REG_INTERRUPTS_ON:
          cfg_d.interrupts_on = cfg_i.data[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charging_interval_ms  <= 21'd5000;
      cfg_q.full_interval_ms      <= 21'd60000;
      cfg_q.error_interval_ms     <= 21'd30000;
      cfg_q.interrupt_interval_ms <= 21'd30000;
      cfg_q.debounce_ms           <= 16'd1000;
      cfg_q.idle_limit_ms         <= 32'd30000;
      cfg_q.edge_holdoff_ms       <= 16'd50;
      cfg_q.interrupts_on         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/csm_tracker.sv @@
// Charge state tracker: holds the monitor state and computes one result
// per event request. Depends on csm_pkg.
`default_nettype none

module csm_tracker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         advance_i,
  input  csm_pkg::item_t    item_i,
  input  csm_pkg::cfg_t     cfg_i,
  output csm_pkg::result_t  result_o
);

  csm_pkg::charge_state_e           cur_q, cur_d;
  logic [csm_pkg::ErrCntW-1:0]      err_q, err_d;
  logic [csm_pkg::TimeW-1:0]        last_change_q, last_change_d;
  logic [csm_pkg::TimeW-1:0]        last_act_q, last_act_d;
  logic [csm_pkg::TimeW-1:0]        last_edge_q, last_edge_d;
  logic [csm_pkg::TimeW-1:0]        edges_q, edges_d;
  logic                             idle_q, idle_d;
  logic                             pend_q, pend_d;
  logic                             fell_q, fell_d;

  logic                             irq_now;
  logic                             irq_next;
  logic                             idle_now;
  logic [csm_pkg::ShortW-1:0]       threshold;
  logic                             debounce_ok;
  csm_pkg::charge_state_e           want;
  csm_pkg::charge_state_e           poll_state;
  logic [1:0]                       err_half;
  logic [csm_pkg::IntervalW+1:0]    err_scaled;
  logic [csm_pkg::IntervalW+1:0]    base;
  logic [csm_pkg::IntervalW+2:0]    scaled;
  logic                             changed;
  logic                             check;
  logic                             is_sample;
  logic                             edge_ok;

  assign irq_now   = cfg_i.interrupts_on & ~fell_q;
  assign irq_next  = cfg_i.interrupts_on & ~fell_d;
  assign idle_now  = (item_i.now_ms - last_act_q) > cfg_i.idle_limit_ms;
  assign threshold = pend_q ? (cfg_i.debounce_ms >> 1) : cfg_i.debounce_ms;
  assign debounce_ok = (item_i.now_ms - last_change_q) >= {16'd0, threshold};
  assign want = item_i.pin_level ? csm_pkg::ST_CHARGING : csm_pkg::ST_FULL;
  assign poll_state = item_i.read_error ? csm_pkg::ST_ERROR : want;
  assign edge_ok = irq_now & ((item_i.now_ms - last_edge_q) >= {16'd0, cfg_i.edge_holdoff_ms});

  always_comb begin
    cur_d         = cur_q;
    err_d         = err_q;
    last_change_d = last_change_q;
    last_act_d    = last_act_q;
    last_edge_d   = last_edge_q;
    edges_d       = edges_q;
    idle_d        = idle_q;
    pend_d        = pend_q;
    fell_d        = fell_q;
    changed       = 1'b0;
    check         = 1'b0;
    is_sample     = 1'b0;
    case (csm_pkg::mode_e'(item_i.mode))
      csm_pkg::MODE_SAMPLE: begin
        is_sample = 1'b1;
        idle_d    = idle_now;
        pend_d    = 1'b0;
        if (item_i.read_error) begin
          fell_d  = fell_q | irq_now;
          err_d   = (err_q < csm_pkg::ErrCap) ? err_q + 3'd1 : err_q;
          changed = (cur_q != csm_pkg::ST_ERROR);
          cur_d   = csm_pkg::ST_ERROR;
        end else begin
          err_d = '0;
          if (want != cur_q && (cur_q == csm_pkg::ST_ERROR || debounce_ok)) begin
            cur_d         = want;
            last_change_d = item_i.now_ms;
            changed       = 1'b1;
          end
        end
      end
      csm_pkg::MODE_EDGE: begin
        if (edge_ok) begin
          last_edge_d = item_i.now_ms;
          edges_d     = edges_q + 32'd1;
          last_act_d  = item_i.now_ms;
          pend_d      = 1'b1;
          check       = 1'b1;
        end
      end
      csm_pkg::MODE_ACTIVITY: begin
        last_act_d = item_i.now_ms;
        idle_d     = 1'b0;
        check      = 1'b1;
      end
      default: check = 1'b0;
    endcase
  end

  // error backoff: base times (1 + count / 2), count already updated
  assign err_half = err_d[2:1];
  always_comb begin
    case (err_half)
      2'd0:    err_scaled = {2'b00, cfg_i.error_interval_ms};
      2'd1:    err_scaled = {1'b0, cfg_i.error_interval_ms, 1'b0};
      2'd2:    err_scaled = {2'b00, cfg_i.error_interval_ms}
                          + {1'b0, cfg_i.error_interval_ms, 1'b0};
      default: err_scaled = {cfg_i.error_interval_ms, 2'b00};
    endcase
  end

  always_comb begin
    if (irq_next) begin
      base = {2'b00, cfg_i.interrupt_interval_ms};
    end else begin
      case (poll_state)
        csm_pkg::ST_CHARGING: base = {2'b00, cfg_i.charging_interval_ms};
        csm_pkg::ST_FULL:     base = {2'b00, cfg_i.full_interval_ms};
        default: begin
          base = (err_scaled > {6'd0, csm_pkg::ErrIntervalCap})
               ? {6'd0, csm_pkg::ErrIntervalCap} : err_scaled;
        end
      endcase
    end
    if (idle_now && poll_state != csm_pkg::ST_CHARGING) begin
      scaled = {base, 1'b0};
    end else begin
      scaled = {1'b0, base};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q         <= csm_pkg::ST_ERROR;
      err_q         <= '0;
      last_change_q <= '0;
      last_act_q    <= '0;
      last_edge_q   <= '0;
      edges_q       <= '0;
      idle_q        <= 1'b0;
      pend_q        <= 1'b0;
      fell_q        <= 1'b0;
    end else if (advance_i) begin
      cur_q         <= cur_d;
      err_q         <= err_d;
      last_change_q <= last_change_d;
      last_act_q    <= last_act_d;
      last_edge_q   <= last_edge_d;
      edges_q       <= edges_d;
      idle_q        <= idle_d;
      pend_q        <= pend_d;
      fell_q        <= fell_d;
    end
  end

  always_comb begin
    result_o.charge_state     = cur_d;
    result_o.state_changed    = changed;
    result_o.next_interval_ms = is_sample ? scaled[csm_pkg::ResIntervalW-1:0] : '0;
    result_o.check_now        = check;
    result_o.interrupt_mode   = irq_next;
    result_o.edge_count       = edges_d;
    result_o.error_count      = err_d;
    result_o.idle             = idle_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/charger_status_monitor.sv @@
// Charger status monitor: tracks a charger status pin (high means charging)
// from timestamped event requests and reports state and next poll interval.
//
// Channels: in_i takes event requests (sample, edge, activity), out_o
// returns exactly one result request per event, cfg_i writes the eight
// configuration registers by index and is always ready; write it only
// while no event is in flight.
// Order: an accepted event waits in the input register; once the output
// register is free or being read, the state update and the result
// computation land in the output register together on the same edge.
// Throughput: one event per cycle while out_o.ready stays high; the single
// state update per cycle between input and output registers sets that figure.
// Stall: when out_o.ready is low the result holds, the input register
// still fills, and in_i.ready drops only when both are occupied.
// Reset: rst_ni clears all tracking state (charge state to error, counts
// and timestamps to zero), restores register defaults and empties the
// pipeline.
// Depends on csm_pkg, csm_if, csm_cfg_regs and csm_tracker.
`default_nettype none

module charger_status_monitor (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  csm_in_if.sink     in_i,
  csm_out_if.source  out_o,
  csm_cfg_if.sink    cfg_i
);

  csm_pkg::cfg_t     cfg;
  csm_pkg::item_t    s1_item_q;
  logic              s1_valid_q;
  logic              s1_adv;
  logic              in_fire;
  csm_pkg::result_t  res;
  csm_pkg::result_t  out_res_q;
  logic              out_valid_q;

  csm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~s1_valid_q | s1_adv;
  assign in_fire    = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.mode       <= in_i.mode;
      s1_item_q.now_ms     <= in_i.now_ms;
      s1_item_q.pin_level  <= in_i.pin_level;
      s1_item_q.read_error <= in_i.read_error;
    end
  end

  csm_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .item_i    (s1_item_q),
    .cfg_i     (cfg),
    .result_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.charge_state     = out_res_q.charge_state;
  assign out_o.state_changed    = out_res_q.state_changed;
  assign out_o.next_interval_ms = out_res_q.next_interval_ms;
  assign out_o.check_now        = out_res_q.check_now;
  assign out_o.interrupt_mode   = out_res_q.interrupt_mode;
  assign out_o.edge_count       = out_res_q.edge_count;
  assign out_o.error_count      = out_res_q.error_count;
  assign out_o.idle             = out_res_q.idle;

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced request did not reach the output register");

  a_err_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_res_q.error_count <= csm_pkg::ErrCap)
    else $error("error count above cap");

  a_err_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.error_count != '0)
      |-> out_res_q.charge_state == csm_pkg::ST_ERROR)
    else $error("read errors counted outside error state");

  a_change_vs_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.state_changed && out_res_q.check_now))
    else $error("state change and check request in one result");

endmodule

`default_nettype wire
